/* rtl/bmhq_pkg.sv */
package bmhq_pkg;

    // stream payload widths, padded to whole bytes
    localparam int IN_W  = 40;  // func(1), value(32)
    localparam int OUT_W = 48;  // top_value(32), top_valid(1), count(11), status(2)

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

/* rtl/binary_min_heap_queue.sv */
// Binary min-heap priority queue of signed keys.
// Request channel (s_*): tdata[0] = func (0 push, 1 pop), tdata[32:1] = value.
// Result channel (m_*): one result per request with the minimum after the
// operation (0 when empty), a valid flag, the entry count and a status
// (0 done, 1 push rejected because full, 2 pop on empty heap).
// The heap lives in one memory with one write port and two read ports,
// each with a registered read. A push walks up from the new leaf, one
// parent read and one compare/write per level. A pop first reads the last
// entry, then walks down from the root reading both children together.
// A walk moves at most log2(CAPACITY) - 1 levels. Rejected requests and a
// pop that empties go straight to the result without a walk.
// One request is worked at a time; s_tready is high only when idle.
// Reset empties the heap at once (count zero); memory contents are not
// cleared. A stalled receiver holds the result in the output register;
// the next request is still accepted and its result waits until the
// register frees.
module binary_min_heap_queue #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bmhq_pkg::IN_W-1:0]    s_tdata,   // func, value, pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bmhq_pkg::OUT_W-1:0]   m_tdata    // top_value, top_valid, count, status, pad
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = ADDR_W + 2;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_RD   = 3'd1;
    localparam logic [2:0] ST_UP_CMP  = 3'd2;
    localparam logic [2:0] ST_DN_LOAD = 3'd3;
    localparam logic [2:0] ST_DN_RD   = 3'd4;
    localparam logic [2:0] ST_DN_CMP  = 3'd5;
    localparam logic [2:0] ST_OUT     = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic [ADDR_W-1:0]                   pos_reg, pos_next;
    logic [KEY_WIDTH-1:0]                key_reg, key_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [bmhq_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [KEY_WIDTH-1:0]                root_reg, root_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [bmhq_pkg::OUT_W-1:0]          m_tdata_reg, m_tdata_next;

    logic [KEY_WIDTH-1:0]                mem [CAPACITY];
    logic                                mem_we;
    logic [ADDR_W-1:0]                   mem_waddr;
    logic [KEY_WIDTH-1:0]                mem_wdata;
    logic [ADDR_W-1:0]                   rd0_addr, rd1_addr;
    logic [KEY_WIDTH-1:0]                rd0_reg, rd1_reg;

    logic                                s_fire;
    logic                                func_in;
    logic [KEY_WIDTH-1:0]                key_in;
    logic [bmhq_pkg::VALUE_W-1:0]        top_ext;
    logic [bmhq_pkg::COUNT_W-1:0]        count_out;
    logic [ADDR_W-1:0]                   parent_addr;
    logic [IDX_W-1:0]                    left_idx, right_idx, n_idx;
    logic                                left_ok, right_ok;
    logic                                take_left, take_right;
    logic [KEY_WIDTH-1:0]                best_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign func_in  = s_tdata[0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // key from the value field, and the reported minimum back to 32 bits
    generate
        if (KEY_WIDTH <= bmhq_pkg::VALUE_W)
        begin : g_key_narrow
            assign key_in = s_tdata[KEY_WIDTH:1];
        end
        else
        begin : g_key_wide
            assign key_in = {{(KEY_WIDTH - bmhq_pkg::VALUE_W){s_tdata[bmhq_pkg::VALUE_W]}},
                             s_tdata[bmhq_pkg::VALUE_W:1]};
        end
        if (KEY_WIDTH < bmhq_pkg::VALUE_W)
        begin : g_top_ext
            assign top_ext = {{(bmhq_pkg::VALUE_W - KEY_WIDTH){root_reg[KEY_WIDTH-1]}},
                              root_reg};
        end
        else
        begin : g_top_cut
            assign top_ext = root_reg[bmhq_pkg::VALUE_W-1:0];
        end
        if (CNT_W >= bmhq_pkg::COUNT_W)
        begin : g_cnt_cut
            assign count_out = cnt_reg[bmhq_pkg::COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign count_out = {{(bmhq_pkg::COUNT_W - CNT_W){1'b0}}, cnt_reg};
        end
    endgenerate

    // tree addressing
    assign parent_addr = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_idx    = {1'b0, pos_reg, 1'b1};
    assign right_idx   = left_idx + IDX_W'(1);
    assign n_idx       = IDX_W'(cnt_reg);
    assign left_ok     = left_idx < n_idx;
    assign right_ok    = right_idx < n_idx;

    // smaller child, left wins ties; move only if strictly smaller than the key
    assign take_left  = $signed(key_reg) > $signed(rd0_reg);
    assign best_val   = take_left ? rd0_reg : key_reg;
    assign take_right = right_ok && ($signed(best_val) > $signed(rd1_reg));

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = key_reg;
        rd0_addr      = parent_addr;
        rd1_addr      = right_idx[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    status_next = bmhq_pkg::STATUS_DONE;
                    pos_next    = '0;
                    if (func_in == bmhq_pkg::FUNC_PUSH)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = bmhq_pkg::STATUS_FULL;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            key_next   = key_in;
                            pos_next   = cnt_reg[ADDR_W-1:0];
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = bmhq_pkg::STATUS_EMPTY;
                            state_next  = ST_OUT;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                            rd0_addr = cnt_next[ADDR_W-1:0];
                            if (cnt_reg == CNT_W'(1))
                                state_next = ST_OUT;
                            else
                                state_next = ST_DN_LOAD;
                        end
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if ($signed(rd0_reg) > $signed(key_reg))
                begin
                    mem_wdata  = rd0_reg;
                    pos_next   = parent_addr;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DN_LOAD:
            begin
                key_next   = rd0_reg;
                state_next = ST_DN_RD;
            end
            ST_DN_RD:
            begin
                rd0_addr = left_idx[ADDR_W-1:0];
                if (!left_ok)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP:
            begin
                mem_we = 1'b1;
                priority if (take_right)
                begin
                    mem_wdata  = rd1_reg;
                    pos_next   = right_idx[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end
                else if (take_left)
                begin
                    mem_wdata  = rd0_reg;
                    pos_next   = left_idx[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(bmhq_pkg::OUT_W - bmhq_pkg::VALUE_W - 1
                                       - bmhq_pkg::COUNT_W - bmhq_pkg::STATUS_W){1'b0}},
                                     status_reg, count_out, (cnt_reg != '0),
                                     (cnt_reg != '0) ? top_ext : '0};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shadow of entry 0 so the minimum never needs a memory read
    always_comb
    begin
        root_next = root_reg;
        if (mem_we && (mem_waddr == '0))
            root_next = mem_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        root_reg    <= root_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd0_reg <= mem[rd0_addr];
        rd1_reg <= mem[rd1_addr];
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CNT_W'(mem_waddr) < cnt_reg))
        else $error("heap write outside the occupied entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (cnt_reg == $past(cnt_reg)))
        else $error("count changed during a sift");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && status_reg == bmhq_pkg::STATUS_EMPTY) |-> (cnt_reg == '0))
        else $error("pop on empty heap with entries present");

    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && status_reg == bmhq_pkg::STATUS_FULL)
        |-> (cnt_reg == CNT_W'(CAPACITY)))
        else $error("push rejected while heap not full");
`endif

endmodule

/* sim/binary_min_heap_queue_tb.sv */
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;

    localparam int HEAP_CAP    = 1024;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 200;
    localparam int DRAIN_WAIT  = 40;

    // fields from MSB down, so the LSB end lines up with m_tdata
    typedef struct packed {
        logic [bmhq_pkg::STATUS_W-1:0]       status;
        logic [bmhq_pkg::COUNT_W-1:0]        count;
        logic                                top_valid;
        logic signed [bmhq_pkg::VALUE_W-1:0] top_value;
    } heap_result_t;

    typedef struct packed {
        logic                          op;
        logic [bmhq_pkg::VALUE_W-1:0]  key;
        logic                          fixed;   // want is typed in, not predicted
        heap_result_t                  want;
    } step_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bmhq_pkg::IN_W-1:0]    s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [bmhq_pkg::OUT_W-1:0]   m_tdata;

    logic signed [bmhq_pkg::VALUE_W-1:0] heap_keys [HEAP_CAP];
    int unsigned                         heap_size;

    heap_result_t pending_results [$];
    step_row_t    directed_rows [$];
    int           errors = 0;
    int           results_checked = 0;
    int           send_quiet = 0;
    int           recv_quiet = 0;

    binary_min_heap_queue #(
        .CAPACITY  (HEAP_CAP),
        .KEY_WIDTH (bmhq_pkg::VALUE_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // applies one request to the local heap and returns what the block should report
    function automatic heap_result_t heap_apply(logic op,
                                                logic signed [bmhq_pkg::VALUE_W-1:0] key);
        heap_result_t                        r;
        int unsigned                         pos;
        int unsigned                         parent;
        int unsigned                         left;
        int unsigned                         right;
        int unsigned                         best;
        logic signed [bmhq_pkg::VALUE_W-1:0] tmp;
        bit                                  done;
        r.status = bmhq_pkg::STATUS_DONE;
        done = 1'b0;
        if (op == bmhq_pkg::FUNC_PUSH)
        begin
            if (heap_size >= HEAP_CAP)
                r.status = bmhq_pkg::STATUS_FULL;
            else
            begin
                pos = heap_size;
                heap_keys[pos] = key;
                heap_size++;
                while (pos > 0 && !done)
                begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[parent] > heap_keys[pos])
                    begin
                        tmp = heap_keys[parent];
                        heap_keys[parent] = heap_keys[pos];
                        heap_keys[pos] = tmp;
                        pos = parent;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        else if (heap_size == 0)
            r.status = bmhq_pkg::STATUS_EMPTY;
        else
        begin
            heap_keys[0] = heap_keys[heap_size - 1];
            heap_size--;
            pos = 0;
            while (!done)
            begin
                left  = 2 * pos + 1;
                right = left + 1;
                best  = pos;
                // left child wins ties; swap only on strictly smaller
                if (left < heap_size && heap_keys[pos] > heap_keys[left])
                    best = left;
                if (right < heap_size && heap_keys[best] > heap_keys[right])
                    best = right;
                if (best == pos)
                    done = 1'b1;
                else
                begin
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        r.top_valid = (heap_size > 0);
        r.top_value = (heap_size > 0) ? heap_keys[0] : '0;
        r.count     = bmhq_pkg::COUNT_W'(heap_size);
        return r;
    endfunction

    // random idle gap before each transfer, with occasional runs of back-to-back transfers
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet = $urandom_range(10, 40);
        return $urandom_range(0, 10);
    endfunction

    // mix of extremes, small keys (plenty of ties) and full-range keys
    function automatic logic [bmhq_pkg::VALUE_W-1:0] draw_key();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return bmhq_pkg::VALUE_W'($urandom_range(0, 16)) - bmhq_pkg::VALUE_W'(8);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic op, input logic [bmhq_pkg::VALUE_W-1:0] key,
                           input logic fixed = 1'b0, input heap_result_t want = '0);
        step_row_t row;
        row.op    = op;
        row.key   = key;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic op, input logic [bmhq_pkg::VALUE_W-1:0] key,
                                input logic fixed, input heap_result_t want);
        int           gap;
        heap_result_t predicted;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(bmhq_pkg::IN_W - bmhq_pkg::VALUE_W - 1){1'b0}}, key, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = heap_apply(op, key);
        pending_results.push_back(fixed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side
    initial
    begin
        heap_result_t want;
        heap_result_t got;
        int           gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(recv_quiet);
            if (results_checked == HOLD_AT)
                gap = LONG_HOLD;   // let the block back up into the request side
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = m_tdata[$bits(heap_result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.top_value !== want.top_value)
                begin
                    $display("%0t: top_value expected %0d actual %0d",
                             $time, want.top_value, got.top_value);
                    errors++;
                end
                if (got.top_valid !== want.top_valid)
                begin
                    $display("%0t: top_valid expected %b actual %b",
                             $time, want.top_valid, got.top_valid);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, got.count);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
            results_checked++;
            @(negedge clk);
        end
    end

    // watchdog: too long without any transfer on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        heap_size       = 0;

        // empty heap, extremes, ties, pops down to empty and past it
        add_row(bmhq_pkg::FUNC_POP,  32'h0,         1'b1,
                {bmhq_pkg::STATUS_EMPTY, 11'd0, 1'b0, 32'h0});
        add_row(bmhq_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 1'b1,
                {bmhq_pkg::STATUS_DONE,  11'd1, 1'b1, 32'h7FFF_FFFF});
        add_row(bmhq_pkg::FUNC_PUSH, 32'h8000_0000, 1'b1,
                {bmhq_pkg::STATUS_DONE,  11'd2, 1'b1, 32'h8000_0000});
        add_row(bmhq_pkg::FUNC_POP,  32'hFFFF_FFFF, 1'b1,
                {bmhq_pkg::STATUS_DONE,  11'd1, 1'b1, 32'h7FFF_FFFF});
        add_row(bmhq_pkg::FUNC_POP,  32'h0,         1'b1,
                {bmhq_pkg::STATUS_DONE,  11'd0, 1'b0, 32'h0});
        add_row(bmhq_pkg::FUNC_POP,  32'h0,         1'b1,
                {bmhq_pkg::STATUS_EMPTY, 11'd0, 1'b0, 32'h0});
        add_row(bmhq_pkg::FUNC_PUSH, 32'd3);
        add_row(bmhq_pkg::FUNC_PUSH, 32'd3);
        add_row(bmhq_pkg::FUNC_PUSH, -32'sd7);
        add_row(bmhq_pkg::FUNC_PUSH, 32'd10);
        add_row(bmhq_pkg::FUNC_PUSH, 32'd3);
        add_row(bmhq_pkg::FUNC_PUSH, 32'h8000_0000);
        add_row(bmhq_pkg::FUNC_PUSH, 32'hFFFF_FFFF);
        repeat (7)
            add_row(bmhq_pkg::FUNC_POP, $urandom);
        add_row(bmhq_pkg::FUNC_POP,  32'h0,         1'b1,
                {bmhq_pkg::STATUS_EMPTY, 11'd0, 1'b0, 32'h0});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key,
                         directed_rows[i].fixed, directed_rows[i].want);

        // sender pause until the block has drained
        s_tvalid = 1'b0;
        wait_all_results();
        @(negedge clk);

        // small heaps, frequent pops on empty
        repeat (40)
            send_request($urandom_range(0, 1) ? bmhq_pkg::FUNC_POP : bmhq_pkg::FUNC_PUSH,
                         draw_key(), 1'b0, '0);

        // fill to capacity with a few pops, then push into the full heap
        while (heap_size < HEAP_CAP)
            send_request(($urandom_range(0, 63) == 0) ? bmhq_pkg::FUNC_POP
                                                      : bmhq_pkg::FUNC_PUSH,
                         draw_key(), 1'b0, '0);
        repeat (6)
            send_request(bmhq_pkg::FUNC_PUSH, draw_key(), 1'b0, '0);

        // deep pops from the full heap
        repeat (30)
            send_request(bmhq_pkg::FUNC_POP, draw_key(), 1'b0, '0);

        s_tvalid = 1'b0;
        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bmhq_pkg.sv
rtl/binary_min_heap_queue.sv
sim/binary_min_heap_queue_tb.sv
